// ===== src/iaf_pkg.sv =====
`timescale 1ns / 1ps
package iaf_pkg;

  // Request codes
  localparam logic [2:0] REQ_UDEC = 3'd0;
  localparam logic [2:0] REQ_SDEC = 3'd1;
  localparam logic [2:0] REQ_HEX  = 3'd2;
  localparam logic [2:0] REQ_OCT  = 3'd3;
  localparam logic [2:0] REQ_PTR  = 3'd4;

  // Widths and digit counts
  localparam int VAL_W       = 64;
  localparam int WIDTH_W     = 8;
  localparam int CHAR_W      = 8;
  localparam int DEC_DIGITS  = 20;
  localparam int HEX_DIGITS  = 16;
  localparam int OCT_DIGITS  = 22;
  localparam int MAX_DIGITS  = 22;
  localparam int POS_W       = 5;
  localparam int BCD_BITS    = DEC_DIGITS * 4;
  localparam int DD_BITS     = 4;
  localparam int CONV_CYCLES = VAL_W / DD_BITS;
  localparam int CNT_W       = 4;
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_CYCLES - 1);
  localparam int LEAD_MAX    = 5;
  localparam int LEAD_W      = 3;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LOWER_N = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_LOWER_I = 8'h69;
  localparam logic [CHAR_W-1:0] CH_LOWER_L = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VAL_W-1:0]   value;
    logic               wide;
    logic               caps;
    logic               zero_pad;
    logic [WIDTH_W-1:0] width;
    logic               show_plus;
    logic               blank_sign;
    logic               alt_form;
  } iaf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } iaf_out_t;

  // One classified item, digits most significant at the highest index
  typedef struct packed {
    logic [LEAD_MAX-1:0][CHAR_W-1:0] lead;
    logic [LEAD_W-1:0]               lead_cnt;
    logic                            has_dig;
    logic [MAX_DIGITS-1:0][3:0]      digs;
    logic [POS_W-1:0]                start;
    logic [POS_W-1:0]                msd;
    logic [POS_W-1:0]                wlim;
    logic                            zeros;
    logic                            caps;
  } iaf_rec_t;

  typedef enum logic [1:0] {FS_IDLE, FS_CONV, FS_HOLD} iaf_fstate_t;
  typedef enum logic [1:0] {BS_IDLE, BS_LEAD, BS_DIGIT} iaf_bstate_t;

  // Four double-dabble steps: adjust every BCD digit, shift in one bit
  function automatic logic [BCD_BITS-1:0] dd_shift4(input logic [BCD_BITS-1:0] bcd_in,
                                                    input logic [DD_BITS-1:0] bits_in);
    logic [BCD_BITS-1:0] acc;
    acc = bcd_in;
    for (int s = DD_BITS - 1; s >= 0; s--) begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
        if (acc[4*i +: 4] >= 4'd5) acc[4*i +: 4] = acc[4*i +: 4] + 4'd3;
      end
      acc = {acc[BCD_BITS-2:0], bits_in[s]};
    end
    return acc;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] ch;
    if (d < 4'd10) ch = CH_ZERO + {4'b0, d};
    else if (upper) ch = CH_UPPER_A + {4'b0, d - 4'd10};
    else ch = CH_LOWER_A + {4'b0, d - 4'd10};
    return ch;
  endfunction

endpackage

// ===== src/iaf_front.sv =====
`timescale 1ns / 1ps
module iaf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  iaf_pkg::iaf_in_t  in_data,
  output logic              busy,
  output logic              push,
  output iaf_pkg::iaf_rec_t push_rec,
  input  logic              q_full
);
  import iaf_pkg::*;

  iaf_fstate_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [VAL_W-1:0]                mag_r;
  logic [BCD_BITS-1:0]             bcd_r;
  logic [2:0]                      type_r;
  logic                            caps_r;
  logic                            zpad_r;
  logic [WIDTH_W-1:0]              width_r;
  logic [LEAD_MAX-1:0][CHAR_W-1:0] lead_r;
  logic [LEAD_W-1:0]               lead_cnt_r;
  logic                            has_dig_r;

  logic                            accept, valid_type, is_dec, neg;
  logic [VAL_W-1:0]                v_sel, mag;
  logic [LEAD_MAX-1:0][CHAR_W-1:0] lead;
  logic [LEAD_W-1:0]               lead_cnt;
  logic                            has_dig;

  logic [MAX_DIGITS-1:0][3:0]      digs;
  logic [POS_W-1:0]                ndig, msd, wlim, first;

  // Classify the incoming item: magnitude, sign and prefix characters
  always_comb begin
    valid_type = in_data.req_type inside {[REQ_UDEC:REQ_PTR]};
    is_dec     = in_data.req_type inside {REQ_UDEC, REQ_SDEC};
    if (in_data.req_type == REQ_PTR || in_data.wide) begin
      v_sel = in_data.value;
    end else if (in_data.req_type == REQ_SDEC && in_data.value[31]) begin
      v_sel = {32'hffff_ffff, in_data.value[31:0]};
    end else begin
      v_sel = {32'h0, in_data.value[31:0]};
    end
    neg = (in_data.req_type == REQ_SDEC) && v_sel[VAL_W-1];
    mag = neg ? (~v_sel + VAL_W'(1)) : v_sel;

    lead     = '0;
    lead_cnt = '0;
    has_dig  = 1'b1;
    case (in_data.req_type)
      REQ_SDEC: begin
        if (neg) begin
          lead[0]  = CH_MINUS;
          lead_cnt = LEAD_W'(1);
        end else if (in_data.show_plus) begin
          lead[0]  = CH_PLUS;
          lead_cnt = LEAD_W'(1);
        end else if (in_data.blank_sign) begin
          lead[0]  = CH_SPACE;
          lead_cnt = LEAD_W'(1);
        end
      end
      REQ_HEX: begin
        if (in_data.alt_form) begin
          lead[0]  = CH_ZERO;
          lead[1]  = in_data.caps ? CH_UPPER_X : CH_LOWER_X;
          lead_cnt = LEAD_W'(2);
        end
      end
      REQ_OCT: begin
        if (in_data.alt_form) begin
          lead[0]  = CH_ZERO;
          lead_cnt = LEAD_W'(1);
        end
      end
      REQ_PTR: begin
        if (mag == '0) begin
          lead[0]  = CH_LPAREN;
          lead[1]  = CH_LOWER_N;
          lead[2]  = CH_LOWER_I;
          lead[3]  = CH_LOWER_L;
          lead[4]  = CH_RPAREN;
          lead_cnt = LEAD_W'(LEAD_MAX);
          has_dig  = 1'b0;
        end else begin
          lead[0]  = CH_ZERO;
          lead[1]  = CH_LOWER_X;
          lead_cnt = LEAD_W'(2);
        end
      end
      default: ;
    endcase
  end

  // Sequencing: convert decimal, then hold until the queue takes the record
  always_comb begin
    busy    = (state_r == FS_CONV) || (state_r == FS_HOLD && q_full);
    push    = (state_r == FS_HOLD) && !q_full;
    accept  = start && !busy;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      FS_IDLE: ;
      FS_CONV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CONV_LAST) state_nxt = FS_HOLD;
      end
      FS_HOLD: begin
        if (push) state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
    if (accept && valid_type) begin
      state_nxt = is_dec ? FS_CONV : FS_HOLD;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && valid_type) begin
      mag_r      <= mag;
      bcd_r      <= '0;
      type_r     <= in_data.req_type;
      caps_r     <= in_data.caps;
      zpad_r     <= in_data.zero_pad;
      width_r    <= in_data.width;
      lead_r     <= lead;
      lead_cnt_r <= lead_cnt;
      has_dig_r  <= has_dig;
    end else if (state_r == FS_CONV) begin
      mag_r <= mag_r << DD_BITS;
      bcd_r <= dd_shift4(bcd_r, mag_r[VAL_W-1 -: DD_BITS]);
    end
  end

  // Build the digit row and the first position to emit
  always_comb begin
    digs = '0;
    case (type_r)
      REQ_UDEC, REQ_SDEC: begin
        for (int i = 0; i < DEC_DIGITS; i++) digs[i] = bcd_r[4*i +: 4];
        ndig = POS_W'(DEC_DIGITS);
      end
      REQ_OCT: begin
        for (int i = 0; i < OCT_DIGITS - 1; i++) digs[i] = {1'b0, mag_r[3*i +: 3]};
        digs[OCT_DIGITS-1] = {3'b0, mag_r[VAL_W-1]};
        ndig = POS_W'(OCT_DIGITS);
      end
      default: begin
        for (int i = 0; i < HEX_DIGITS; i++) digs[i] = mag_r[4*i +: 4];
        ndig = POS_W'(HEX_DIGITS);
      end
    endcase
    msd = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digs[i] != 4'd0) msd = POS_W'(i);
    end
    wlim  = (width_r > {{(WIDTH_W - POS_W){1'b0}}, ndig}) ? ndig : width_r[POS_W-1:0];
    first = msd;
    if (wlim != '0 && (wlim - POS_W'(1)) > msd) first = wlim - POS_W'(1);

    push_rec.lead     = lead_r;
    push_rec.lead_cnt = lead_cnt_r;
    push_rec.has_dig  = has_dig_r;
    push_rec.digs     = digs;
    push_rec.start    = first;
    push_rec.msd      = msd;
    push_rec.wlim     = wlim;
    push_rec.zeros    = zpad_r && (type_r != REQ_PTR);
    push_rec.caps     = caps_r && (type_r == REQ_HEX);
  end

`ifndef SYNTHESIS
  a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_CONV && cnt_r == CONV_LAST) |=> (state_r == FS_HOLD))
    else $error("conversion did not finish after its last step");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_HOLD && q_full) |=> (state_r == FS_HOLD && $stable(lead_r)))
    else $error("held record changed while the queue was full");
  a_rec_start: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_rec.start >= push_rec.msd && push_rec.start < ndig))
    else $error("first position out of range");
`endif

endmodule

// ===== src/iaf_queue.sv =====
`timescale 1ns / 1ps
module iaf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  iaf_pkg::iaf_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output iaf_pkg::iaf_rec_t pop_rec,
  output logic              empty
);
  import iaf_pkg::*;

  iaf_rec_t            slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
    empty    = (cnt_r == '0);
    pop_rec  = slot_r[rptr_r];
    wptr_nxt = push ? wptr_r + Q_PTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + Q_PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_rec;
  end

endmodule

// ===== src/iaf_back.sv =====
`timescale 1ns / 1ps
module iaf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  iaf_pkg::iaf_rec_t q_rec,
  output logic              pop,
  output logic              out_strobe,
  output iaf_pkg::iaf_out_t out_data
);
  import iaf_pkg::*;

  iaf_bstate_t       state_r, state_nxt;
  iaf_rec_t          cur_r, cur_nxt;
  logic [LEAD_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  iaf_out_t          out_data_r, out_data_nxt;

  logic              done, show, lead_end;
  logic [3:0]        dig;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '{out_char: CH_SPACE, last: 1'b0};
    done           = 1'b0;
    dig            = cur_r.digs[pos_r];
    show           = (pos_r <= cur_r.msd) || (cur_r.zeros && pos_r < cur_r.wlim);
    lead_end       = (idx_r == cur_r.lead_cnt - LEAD_W'(1));
    case (state_r)
      BS_IDLE: done = 1'b1;
      BS_LEAD: begin
        out_strobe_nxt        = 1'b1;
        out_data_nxt.out_char = cur_r.lead[idx_r];
        out_data_nxt.last     = lead_end && !cur_r.has_dig;
        if (lead_end) begin
          if (cur_r.has_dig) begin
            state_nxt = BS_DIGIT;
            pos_nxt   = cur_r.start;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + LEAD_W'(1);
        end
      end
      BS_DIGIT: begin
        out_strobe_nxt        = 1'b1;
        out_data_nxt.out_char = show ? digit_char(dig, cur_r.caps) : CH_SPACE;
        out_data_nxt.last     = (pos_r == '0);
        if (pos_r == '0) done = 1'b1;
        else pos_nxt = pos_r - POS_W'(1);
      end
      default: done = 1'b1;
    endcase

    // Take the next record as the current one finishes
    pop = done && !q_empty;
    if (done) begin
      if (!q_empty) begin
        cur_nxt   = q_rec;
        idx_nxt   = '0;
        pos_nxt   = q_rec.start;
        state_nxt = (q_rec.lead_cnt != '0) ? BS_LEAD : BS_DIGIT;
      end else begin
        state_nxt = BS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  a_lead_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_LEAD) |-> (idx_r < cur_r.lead_cnt))
    else $error("prefix index past prefix length");
  a_digit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_DIGIT) |-> (pos_r <= cur_r.start))
    else $error("digit position above first position");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BS_IDLE) |=> out_strobe_r)
    else $error("active cycle produced no character");
`endif

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// Integer to ASCII formatter: prints one integer per item as ASCII characters.
// Input: drive in_data and raise start; the item is taken at a clock edge
// where start is high and busy is low. Request types 5 to 7 are taken and
// dropped with no output.
// Output: one character per cycle on out_data with out_strobe high for that
// cycle only; out_data.last marks the final character of the number. The
// receiver cannot stall, so characters leave as soon as they are formed.
// Front end: classifies the item, forms sign and prefix characters, and for
// decimal runs a double-dabble converter 4 bits per cycle.
// A 2-entry record queue decouples it from the back end, which emits one
// character per cycle with no gap between queued items.
// Path to the first character: front-end record, queue slot, back-end record
// and output register, after decimal conversion, plus waits on earlier items.
// Throughput: one character per cycle; an item holds the back end while its
// characters leave (at most 23). Decimal items occupy the front end through
// conversion and the hold state, others only the hold state, so busy rises
// when conversion runs or the queue backs up behind a long item.
// Reset: synchronous, active low; clears the converter, queue and emitter,
// and drops any item in flight.
module integer_to_ascii_formatter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  iaf_pkg::iaf_in_t  in_data,
  output logic              out_strobe,
  output iaf_pkg::iaf_out_t out_data
);
  import iaf_pkg::*;

  logic     push, pop, q_full, q_empty;
  iaf_rec_t push_rec, pop_rec;

  // Classify and convert
  iaf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  // Hold records between the two halves
  iaf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  // Emit characters
  iaf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rec      (pop_rec),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== verif/iaf_checker.sv =====
`timescale 1ns / 1ps
module iaf_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  iaf_pkg::iaf_in_t  in_data,
  input  logic              out_strobe,
  input  iaf_pkg::iaf_out_t out_data,
  output int                err_count,
  output int                waiting,
  output int                chars_checked
);
  import iaf_pkg::*;

  localparam int LINE_MAX = 23;
  localparam logic [127:0] HEX_LOWER = "0123456789abcdef";
  localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";

  iaf_out_t         expected_chars[$];
  logic [7:0]       line_buf[0:LINE_MAX-1];
  int               line_len;
  int               errs;
  int               nchk;

  function automatic void put_char(input logic [7:0] c);
    line_buf[line_len] = c;
    line_len++;
  endfunction

  function automatic void put_decimal(input logic [63:0] num, input logic zeros, input int w);
    logic [63:0] div;
    logic [63:0] d;
    logic        shown;
    div   = 64'd10_000_000_000_000_000_000;
    shown = 1'b0;
    for (int pos = 19; pos >= 0; pos--) begin
      d = num / div;
      if (d != 0 || pos == 0) shown = 1'b1;
      if (zeros && pos < w) shown = 1'b1;
      if (shown) put_char(CH_ZERO + d[7:0]);
      else if (!zeros && pos < w) put_char(CH_SPACE);
      num = num - d * div;
      div = div / 10;
    end
  endfunction

  function automatic void put_pow2(input logic [63:0] num, input int bits, input int top,
                                   input logic upper, input logic zeros, input int w);
    logic [3:0] d;
    logic       shown;
    shown = 1'b0;
    for (int sh = top; sh >= 0; sh -= bits) begin
      d = 4'((num >> sh) & ((64'd1 << bits) - 1));
      if (d != 0 || sh < bits) shown = 1'b1;
      if (zeros && sh < bits * w) shown = 1'b1;
      if (shown) put_char(upper ? HEX_UPPER[8*(15-d) +: 8] : HEX_LOWER[8*(15-d) +: 8]);
      else if (!zeros && sh < bits * w) put_char(CH_SPACE);
    end
  endfunction

  // Format one item into line_buf, then queue its characters
  function automatic void format_number(input iaf_in_t it);
    logic [63:0] v;
    iaf_out_t    ch;
    line_len = 0;
    if (it.req_type > REQ_PTR) return;
    if (it.req_type == REQ_PTR || it.wide) v = it.value;
    else if (it.req_type == REQ_SDEC) v = {{32{it.value[31]}}, it.value[31:0]};
    else v = {32'd0, it.value[31:0]};

    case (it.req_type)
      REQ_UDEC: begin
        put_decimal(v, it.zero_pad, int'(it.width));
      end
      REQ_SDEC: begin
        if (v[63]) begin
          put_char(CH_MINUS);
          v = -v;
        end else if (it.show_plus) begin
          put_char(CH_PLUS);
        end else if (it.blank_sign) begin
          put_char(CH_SPACE);
        end
        put_decimal(v, it.zero_pad, int'(it.width));
      end
      REQ_HEX: begin
        if (it.alt_form) begin
          put_char(CH_ZERO);
          put_char(it.caps ? CH_UPPER_X : CH_LOWER_X);
        end
        put_pow2(v, 4, 60, it.caps, it.zero_pad, int'(it.width));
      end
      REQ_OCT: begin
        if (it.alt_form) put_char(CH_ZERO);
        put_pow2(v, 3, 63, 1'b0, it.zero_pad, int'(it.width));
      end
      default: begin
        if (v == 0) begin
          put_char(CH_LPAREN);
          put_char(CH_LOWER_N);
          put_char(CH_LOWER_I);
          put_char(CH_LOWER_L);
          put_char(CH_RPAREN);
        end else begin
          put_char(CH_ZERO);
          put_char(CH_LOWER_X);
          put_pow2(v, 4, 60, 1'b0, 1'b0, int'(it.width));
        end
      end
    endcase

    for (int i = 0; i < line_len; i++) begin
      ch.out_char = line_buf[i];
      ch.last     = (i == line_len - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    iaf_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          errs++;
          $error("unexpected character 0x%02h (last %0b)", out_data.out_char, out_data.last);
        end else begin
          want = expected_chars.pop_front();
          nchk++;
          if (out_data.out_char !== want.out_char) begin
            errs++;
            $error("out_char: expected 0x%02h, actual 0x%02h", want.out_char, out_data.out_char);
          end
          if (out_data.last !== want.last) begin
            errs++;
            $error("last: expected %0b, actual %0b", want.last, out_data.last);
          end
        end
      end
      if (start && !busy) format_number(in_data);
    end
    err_count     <= errs;
    waiting       <= expected_chars.size();
    chars_checked <= nchk;
  end

endmodule

// ===== verif/integer_to_ascii_formatter_tb.sv =====
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
  import iaf_pkg::*;

  // Longest quiet stretch a correct run can show: a random pause, a decimal
  // conversion and the queue drain together; allow plenty.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 360;
  localparam int TAIL_CYCLES  = 40;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  iaf_in_t  in_data;
  logic     out_strobe;
  iaf_out_t out_data;

  int err_count;
  int waiting;
  int chars_checked;
  int idle_cycles;
  int items_sent;
  int items_dropped;
  logic burst_mode;

  integer_to_ascii_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  iaf_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_strobe   (out_strobe),
    .out_data     (out_data),
    .err_count    (err_count),
    .waiting      (waiting),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles in which neither an item nor a character moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic iaf_in_t make_item(input logic [2:0] req, input logic [63:0] value,
                                        input logic wide, input logic caps,
                                        input logic zero_pad, input logic [7:0] width,
                                        input logic show_plus, input logic blank_sign,
                                        input logic alt_form);
    iaf_in_t it;
    it.req_type   = req;
    it.value      = value;
    it.wide       = wide;
    it.caps       = caps;
    it.zero_pad   = zero_pad;
    it.width      = width;
    it.show_plus  = show_plus;
    it.blank_sign = blank_sign;
    it.alt_form   = alt_form;
    return it;
  endfunction

  // Mix of value shapes: edges and sign boundaries show up often
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = 64'(($urandom_range(0, 999)));
      2: v = ~64'd0;
      3: v = 64'd1 << $urandom_range(0, 63);
      4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      5: v = {32'(-$signed(32'($urandom_range(1, 1000)))), 32'($urandom)};
      6: v = {$urandom, 32'h8000_0000};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic iaf_in_t random_item();
    iaf_in_t it;
    it.req_type   = 3'($urandom_range(REQ_UDEC, REQ_PTR));
    if ($urandom_range(0, 19) == 0) it.req_type = 3'($urandom_range(REQ_PTR + 1, 7));
    it.value      = random_value();
    it.wide       = 1'($urandom);
    it.caps       = 1'($urandom);
    it.zero_pad   = 1'($urandom);
    it.width      = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 24))
                                               : 8'($urandom_range(0, 255));
    it.show_plus  = 1'($urandom);
    it.blank_sign = 1'($urandom);
    it.alt_form   = 1'($urandom);
    return it;
  endfunction

  // Present one item after a random pause, none in burst mode, and hold it
  // until busy is low. Return at the edge that takes it, with start still high.
  task automatic send_item(input iaf_in_t it);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.req_type > REQ_PTR) items_dropped++;
    else items_sent++;
  endtask

  // Drop start and hold off until every queued character has come out
  task automatic drain_output();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    iaf_in_t directed[$];
    start      <= 1'b0;
    in_data    <= '0;
    rst_n      <= 1'b0;
    burst_mode = 1'b0;
    items_sent = 0;
    items_dropped = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: field extremes, every request, the special cases
    directed.push_back(make_item(REQ_UDEC, 64'd0, 1, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(REQ_UDEC, ~64'd0, 1, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(REQ_UDEC, ~64'd0, 0, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(REQ_UDEC, 64'd42, 1, 1, 1, 8'd255, 1, 1, 1));
    directed.push_back(make_item(REQ_UDEC, 64'd42, 1, 0, 0, 8'd5, 0, 0, 0));
    directed.push_back(make_item(REQ_SDEC, 64'h8000_0000_0000_0000, 1, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(REQ_SDEC, 64'h1234_5678_8000_0000, 0, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(REQ_SDEC, ~64'd0, 1, 0, 1, 8'd8, 0, 0, 0));
    directed.push_back(make_item(REQ_SDEC, ~64'd0, 1, 0, 0, 8'd8, 1, 1, 0));
    directed.push_back(make_item(REQ_SDEC, 64'd7, 1, 0, 0, 8'd3, 1, 0, 0));
    directed.push_back(make_item(REQ_SDEC, 64'd7, 1, 0, 1, 8'd3, 0, 1, 1));
    directed.push_back(make_item(REQ_SDEC, 64'h7fff_ffff_ffff_ffff, 1, 1, 0, 8'd255, 1, 1, 0));
    directed.push_back(make_item(REQ_HEX, 64'd0, 1, 1, 0, 8'd0, 0, 0, 1));
    directed.push_back(make_item(REQ_HEX, ~64'd0, 1, 1, 0, 8'd0, 1, 1, 0));
    directed.push_back(make_item(REQ_HEX, 64'hab, 1, 0, 0, 8'd20, 0, 0, 1));
    directed.push_back(make_item(REQ_HEX, 64'hdead_beef_cafe_f00d, 0, 0, 1, 8'd12, 0, 0, 0));
    directed.push_back(make_item(REQ_OCT, 64'd0, 1, 0, 0, 8'd0, 0, 0, 1));
    directed.push_back(make_item(REQ_OCT, ~64'd0, 1, 1, 0, 8'd0, 0, 0, 1));
    directed.push_back(make_item(REQ_OCT, 64'o777, 1, 0, 1, 8'd30, 1, 1, 0));
    directed.push_back(make_item(REQ_PTR, 64'd0, 1, 1, 1, 8'd20, 1, 1, 1));
    directed.push_back(make_item(REQ_PTR, 64'h1000, 1, 0, 0, 8'd20, 0, 0, 0));
    directed.push_back(make_item(REQ_PTR, 64'hffff_0000_0000_0abc, 0, 1, 1, 8'd3, 0, 0, 1));
    directed.push_back(make_item(REQ_PTR + 3'd1, 64'd5, 1, 0, 0, 8'd0, 0, 0, 0));
    directed.push_back(make_item(3'd7, ~64'd0, 1, 1, 1, 8'd255, 1, 1, 1));
    directed.push_back(make_item(REQ_UDEC, 64'd1, 1, 0, 0, 8'd1, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);
    drain_output();

    // Random items; flip between paced and back-to-back stretches now and then
    while (items_sent < RANDOM_ITEMS + directed.size()) begin
      if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
      if (items_sent == directed.size() + RANDOM_ITEMS / 2) drain_output();
      send_item(random_item());
    end

    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d formatted items and %0d dropped request types,", items_sent,
             items_dropped);
    $display("all five requests with random flags, widths and value shapes; %0d chars checked",
             chars_checked);
    if (err_count == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/iaf_pkg.sv
src/iaf_front.sv
src/iaf_queue.sv
src/iaf_back.sv
src/integer_to_ascii_formatter.sv
verif/iaf_checker.sv
verif/integer_to_ascii_formatter_tb.sv
